/* hdl/cst_pkg.sv */
package cst_pkg;

  // Scan mode between characters.
  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_WORD    = 2'd3
  } mode_t;

  // Event codes of a result.
  typedef enum logic [2:0] {
    EV_CHAR   = 3'd0,
    EV_END    = 3'd1,
    EV_UNTERM = 3'd2,
    EV_EOI    = 3'd3,
    EV_EMPTY  = 3'd4
  } event_t;

  // Token classes.
  typedef enum logic [1:0] {
    CLS_SINGLE = 2'd0,
    CLS_STRING = 2'd1,
    CLS_WORD   = 2'd2
  } class_t;

  // Character constants.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // Most results that one character can cause.
  localparam int MAX_RESULTS = 3;

  // One result item.
  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
    class_t     cls;
  } result_t;

  // Decoded work for one character: a count and up to three results.
  typedef struct packed {
    logic [1:0]                      count;
    result_t [MAX_RESULTS-1:0]       res;
  } cmd_t;

  function automatic logic is_single(input logic [7:0] c);
    logic hit;
    begin
      hit = 1'b0;
      case (c) inside
        8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D: hit = 1'b1;
        default: hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

  function automatic logic is_skip_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
  endfunction

  function automatic logic is_vt_ff(input logic [7:0] c);
    return (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic result_t mk_result(input event_t ev, input logic [7:0] c,
                                        input class_t cls);
    result_t r;
    begin
      r.ev  = ev;
      r.ch  = c;
      r.cls = cls;
      return r;
    end
  endfunction

endpackage

/* hdl/cst_in_if.sv */
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source(output valid, output ch, output end_of_input, input ready);
  modport sink(input valid, input ch, input end_of_input, output ready);
endinterface

/* hdl/cst_out_if.sv */
interface cst_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] token_char;
  logic [1:0] token_class;
  logic       last;

  modport source(output valid, output event_res, output token_char, output token_class,
                 output last, input ready);
  modport sink(input valid, input event_res, input token_char, input token_class,
               input last, output ready);
endinterface

/* hdl/cst_front.sv */
module cst_front
  import cst_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  cst_in_if.sink char_in,
  input  logic  queue_full,
  output logic  push,
  output cmd_t  push_cmd
);

  mode_t      scan_mode;
  mode_t      scan_mode_next;
  logic       accept;
  logic       eoi;
  logic [7:0] c;

  assign char_in.ready = !queue_full;
  assign accept        = char_in.valid && char_in.ready;
  assign c             = char_in.ch;
  assign eoi           = char_in.end_of_input || (c == CH_NUL);
  assign push          = accept && (push_cmd.count != 2'd0);

  // Scan mode register, advanced on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_BETWEEN;
    end else if (accept) begin
      scan_mode <= scan_mode_next;
    end
  end

  // Classify the character and build the results it causes.
  always_comb begin
    push_cmd       = '0;
    scan_mode_next = scan_mode;
    if (eoi) begin
      scan_mode_next = MODE_BETWEEN;
      case (scan_mode)
        MODE_STRING: begin
          push_cmd.res[0] = mk_result(EV_UNTERM, CH_NUL, CLS_STRING);
          push_cmd.res[1] = mk_result(EV_END, CH_NUL, CLS_STRING);
          push_cmd.res[2] = mk_result(EV_EOI, CH_NUL, CLS_SINGLE);
          push_cmd.count  = 2'd3;
        end
        MODE_WORD: begin
          push_cmd.res[0] = mk_result(EV_END, CH_NUL, CLS_WORD);
          push_cmd.res[1] = mk_result(EV_EOI, CH_NUL, CLS_SINGLE);
          push_cmd.count  = 2'd2;
        end
        default: begin
          push_cmd.res[0] = mk_result(EV_EOI, CH_NUL, CLS_SINGLE);
          push_cmd.count  = 2'd1;
        end
      endcase
    end else begin
      case (scan_mode)
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            scan_mode_next = MODE_BETWEEN;
          end
        end
        MODE_STRING: begin
          push_cmd.res[0] = mk_result(EV_CHAR, c, CLS_STRING);
          push_cmd.count  = 2'd1;
          if (c == CH_QUOTE) begin
            push_cmd.res[1] = mk_result(EV_END, CH_NUL, CLS_STRING);
            push_cmd.count  = 2'd2;
            scan_mode_next  = MODE_BETWEEN;
          end
        end
        MODE_WORD: begin
          if (is_single(c)) begin
            push_cmd.res[0] = mk_result(EV_END, CH_NUL, CLS_WORD);
            push_cmd.res[1] = mk_result(EV_CHAR, c, CLS_SINGLE);
            push_cmd.res[2] = mk_result(EV_END, CH_NUL, CLS_SINGLE);
            push_cmd.count  = 2'd3;
            scan_mode_next  = MODE_BETWEEN;
          end else if (is_skip_space(c)) begin
            push_cmd.res[0] = mk_result(EV_END, CH_NUL, CLS_WORD);
            push_cmd.count  = 2'd1;
            scan_mode_next  = MODE_BETWEEN;
          end else if (is_vt_ff(c)) begin
            push_cmd.res[0] = mk_result(EV_END, CH_NUL, CLS_WORD);
            push_cmd.res[1] = mk_result(EV_EMPTY, CH_NUL, CLS_SINGLE);
            push_cmd.count  = 2'd2;
            scan_mode_next  = MODE_BETWEEN;
          end else if (c == CH_HASH) begin
            push_cmd.res[0] = mk_result(EV_END, CH_NUL, CLS_WORD);
            push_cmd.count  = 2'd1;
            scan_mode_next  = MODE_COMMENT;
          end else begin
            push_cmd.res[0] = mk_result(EV_CHAR, c, CLS_WORD);
            push_cmd.count  = 2'd1;
          end
        end
        MODE_BETWEEN: begin
          if (is_skip_space(c)) begin
            scan_mode_next = MODE_BETWEEN;
          end else if (c == CH_HASH) begin
            scan_mode_next = MODE_COMMENT;
          end else if (is_single(c)) begin
            push_cmd.res[0] = mk_result(EV_CHAR, c, CLS_SINGLE);
            push_cmd.res[1] = mk_result(EV_END, CH_NUL, CLS_SINGLE);
            push_cmd.count  = 2'd2;
          end else if (c == CH_QUOTE) begin
            push_cmd.res[0] = mk_result(EV_CHAR, c, CLS_STRING);
            push_cmd.count  = 2'd1;
            scan_mode_next  = MODE_STRING;
          end else if (is_vt_ff(c)) begin
            push_cmd.res[0] = mk_result(EV_EMPTY, CH_NUL, CLS_SINGLE);
            push_cmd.count  = 2'd1;
          end else begin
            push_cmd.res[0] = mk_result(EV_CHAR, c, CLS_WORD);
            push_cmd.count  = 2'd1;
            scan_mode_next  = MODE_WORD;
          end
        end
        default: begin
          scan_mode_next = MODE_BETWEEN;
        end
      endcase
    end
  end

endmodule

/* hdl/cst_queue.sv */
module cst_queue
  import cst_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/cst_back.sv */
module cst_back
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  cst_out_if.source tok_out
);

  logic [1:0] idx;
  logic       fire;
  logic       is_last;
  result_t    cur;

  assign cur     = head_cmd.res[idx];
  assign is_last = (idx == head_cmd.count - 2'd1);
  assign fire    = tok_out.valid && tok_out.ready;
  assign pop     = fire && is_last;

  // Present the current result of the head entry.
  assign tok_out.valid       = head_valid;
  assign tok_out.event_res   = cur.ev;
  assign tok_out.token_char  = cur.ch;
  assign tok_out.token_class = cur.cls;
  assign tok_out.last        = is_last;

  // Step through the results of the head entry, one per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

/* hdl/char_stream_tokenizer.sv */
// A result is offered from the queue head, where the decoded work of its character
// is registered on acceptance. Throughput: one character per cycle while the queue
// has room; a character that causes k results gives k output transactions, one result each.
// The decoded-work queue (QUEUE_DEPTH entries) absorbs output stalls.
// Reset (synchronous, active high) returns the scan mode to between tokens
// and empties the queue.
module char_stream_tokenizer
  import cst_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  cst_in_if.sink    char_in,
  cst_out_if.source tok_out
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // Classify characters and track the scan mode.
  cst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .queue_full (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Decouple the front from output stalls.
  cst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Emit the results of each entry in order.
  cst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .tok_out    (tok_out)
  );

endmodule

/* tb/tb_char_stream_tokenizer.sv */
`timescale 1ns / 100ps

module tb_char_stream_tokenizer;
  import cst_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 180;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AFTER   = 60;
  localparam int HOLD_CYCLES  = 90;
  localparam int MAX_PRINTS   = 40;
  localparam string PUNCT_CHARS = "()[],+-*/=";

  // One source character waiting to be sent.
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    logic       drain_first;
  } char_item_t;

  // One result that the tokenizer should produce.
  typedef struct {
    event_t     ev;
    logic [7:0] ch;
    class_t     cls;
    logic       last;
  } token_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cst_in_if  char_in();
  cst_out_if tok_out();

  char_stream_tokenizer dut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .tok_out (tok_out)
  );

  char_item_t   char_queue[$];
  token_event_t expected_tokens[$];
  mode_t        scan_state = MODE_BETWEEN;

  logic        drain_next = 1'b0;
  int          stimulus_count = 0;
  int          errors = 0;
  int          chars_accepted = 0;
  int          eoi_accepted = 0;
  int          results_checked = 0;
  int          event_seen[5] = '{default: 0};
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          idle_cycles = 0;
  logic [15:0] cycle_count = '0;
  logic        quiet_window;

  // While cycle_count[7:6] is zero, a quarter of the time, neither side picks a gap.
  assign quiet_window = (cycle_count[7:6] == 2'b00);

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
    errors++;
  endtask

  // Gap lengths: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet_window) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    for (int i = 0; i < PUNCT_CHARS.len(); i++) begin
      if (c == PUNCT_CHARS[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic is_vert_ctl(input logic [7:0] c);
    return c == CH_VT || c == CH_FF;
  endfunction

  function automatic void add_expected(input event_t ev, input logic [7:0] c,
                                       input class_t cls);
    token_event_t t;
    t.ev   = ev;
    t.ch   = c;
    t.cls  = cls;
    t.last = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  // Predicts the results of one accepted character and advances the scan state.
  function automatic void tokenize_char(input logic [7:0] c, input logic eoi_flag);
    int start_size;
    start_size = expected_tokens.size();
    if (eoi_flag || c == CH_NUL) begin
      if (scan_state == MODE_STRING) begin
        add_expected(EV_UNTERM, 8'h00, CLS_STRING);
        add_expected(EV_END, 8'h00, CLS_STRING);
      end else if (scan_state == MODE_WORD) begin
        add_expected(EV_END, 8'h00, CLS_WORD);
      end
      add_expected(EV_EOI, 8'h00, CLS_SINGLE);
      scan_state = MODE_BETWEEN;
    end else begin
      case (scan_state)
        MODE_COMMENT: begin
          if (c == CH_LF) scan_state = MODE_BETWEEN;
        end
        MODE_STRING: begin
          add_expected(EV_CHAR, c, CLS_STRING);
          if (c == CH_QUOTE) begin
            add_expected(EV_END, 8'h00, CLS_STRING);
            scan_state = MODE_BETWEEN;
          end
        end
        MODE_WORD: begin
          if (is_punct(c)) begin
            add_expected(EV_END, 8'h00, CLS_WORD);
            add_expected(EV_CHAR, c, CLS_SINGLE);
            add_expected(EV_END, 8'h00, CLS_SINGLE);
            scan_state = MODE_BETWEEN;
          end else if (is_blank(c)) begin
            add_expected(EV_END, 8'h00, CLS_WORD);
            scan_state = MODE_BETWEEN;
          end else if (is_vert_ctl(c)) begin
            add_expected(EV_END, 8'h00, CLS_WORD);
            add_expected(EV_EMPTY, 8'h00, CLS_SINGLE);
            scan_state = MODE_BETWEEN;
          end else if (c == CH_HASH) begin
            add_expected(EV_END, 8'h00, CLS_WORD);
            scan_state = MODE_COMMENT;
          end else begin
            add_expected(EV_CHAR, c, CLS_WORD);
          end
        end
        default: begin
          if (is_blank(c)) begin
            // Whitespace between tokens is skipped.
          end else if (c == CH_HASH) begin
            scan_state = MODE_COMMENT;
          end else if (is_punct(c)) begin
            add_expected(EV_CHAR, c, CLS_SINGLE);
            add_expected(EV_END, 8'h00, CLS_SINGLE);
          end else if (c == CH_QUOTE) begin
            add_expected(EV_CHAR, c, CLS_STRING);
            scan_state = MODE_STRING;
          end else if (is_vert_ctl(c)) begin
            add_expected(EV_EMPTY, 8'h00, CLS_SINGLE);
          end else begin
            add_expected(EV_CHAR, c, CLS_WORD);
            scan_state = MODE_WORD;
          end
        end
      endcase
    end
    if (expected_tokens.size() > start_size) begin
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic queue_char(input logic [7:0] c, input logic eoi_flag);
    char_item_t item;
    item.ch          = c;
    item.eoi         = eoi_flag;
    item.drain_first = drain_next;
    drain_next       = 1'b0;
    char_queue.push_back(item);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i], 1'b0);
    end
  endtask

  // Any byte that neither ends nor opens something special inside a word.
  function automatic logic [7:0] pick_word_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (is_punct(c) || is_blank(c) || is_vert_ctl(c) || c == CH_HASH || c == CH_QUOTE)
      c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic queue_comment();
    logic [7:0] c;
    queue_char(CH_HASH, 1'b0);
    repeat ($urandom_range(0, 4)) begin
      c = 8'($urandom_range(1, 255));
      if (c == CH_LF) c = CH_SPACE;
      queue_char(c, 1'b0);
    end
    queue_char(CH_LF, 1'b0);
  endtask

  // Appends one random source fragment, mostly well formed.
  task automatic queue_fragment();
    int         r;
    int         len;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      len = $urandom_range(1, 6);
      // Occasionally a quote sits inside the word.
      queue_char(pick_word_char(), 1'b0);
      for (int i = 1; i < len; i++) begin
        queue_char(($urandom_range(0, 9) == 0) ? CH_QUOTE : pick_word_char(), 1'b0);
      end
      stimulus_count += len + 1;
      case ($urandom_range(0, 6))
        0: queue_char(CH_SPACE, 1'b0);
        1: queue_char(($urandom_range(0, 1) == 1) ? CH_TAB : CH_CR, 1'b0);
        2: queue_char(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)], 1'b0);
        3: queue_char(($urandom_range(0, 1) == 1) ? CH_VT : CH_FF, 1'b0);
        4: queue_comment();
        5: queue_char(8'($urandom_range(0, 255)), 1'b1);
        default: queue_char(CH_LF, 1'b0);
      endcase
    end else if (r < 45) begin
      queue_char(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)], 1'b0);
      stimulus_count++;
    end else if (r < 60) begin
      len = $urandom_range(0, 5);
      queue_char(CH_QUOTE, 1'b0);
      repeat (len) begin
        c = ($urandom_range(0, 5) == 0) ? CH_LF : 8'($urandom_range(1, 255));
        if (c == CH_QUOTE) c = CH_HASH;
        queue_char(c, 1'b0);
      end
      // A few strings are left open and cut off by end of input.
      if ($urandom_range(0, 7) == 0) begin
        queue_char(CH_NUL, 1'b0);
      end else begin
        queue_char(CH_QUOTE, 1'b0);
      end
      stimulus_count += len + 2;
    end else if (r < 68) begin
      queue_comment();
    end else if (r < 76) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0: queue_char(CH_SPACE, 1'b0);
          1: queue_char(CH_TAB, 1'b0);
          2: queue_char(CH_CR, 1'b0);
          default: queue_char(CH_LF, 1'b0);
        endcase
      end
    end else if (r < 80) begin
      queue_char(($urandom_range(0, 1) == 1) ? CH_VT : CH_FF, 1'b0);
      stimulus_count++;
    end else if (r < 85) begin
      if ($urandom_range(0, 1) == 1) begin
        queue_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        queue_char(CH_NUL, 1'b0);
      end
      stimulus_count++;
    end else begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
      stimulus_count += len;
    end
  endtask

  // Driver: offers queued characters with random gaps and predicts on acceptance.
  always @(posedge clk) begin : drive_chars
    char_item_t item;
    if (rst) begin
      char_in.valid        <= 1'b0;
      char_in.ch           <= '0;
      char_in.end_of_input <= 1'b0;
      send_gap             <= 0;
    end else begin
      if (char_in.valid && char_in.ready) begin
        tokenize_char(char_in.ch, char_in.end_of_input);
        chars_accepted <= chars_accepted + 1;
        if (char_in.end_of_input || char_in.ch == CH_NUL) eoi_accepted <= eoi_accepted + 1;
      end
      if (!char_in.valid || char_in.ready) begin
        if (send_gap > 0) begin
          char_in.valid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (char_queue.size() > 0 &&
                     (!char_queue[0].drain_first || expected_tokens.size() == 0)) begin
          item = char_queue.pop_front();
          char_in.ch           <= item.ch;
          char_in.end_of_input <= item.eoi;
          char_in.valid        <= 1'b1;
          send_gap             <= pick_gap();
        end else begin
          char_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and throttles ready.
  always @(posedge clk) begin : check_tokens
    token_event_t want;
    if (rst) begin
      tok_out.ready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (tok_out.valid && tok_out.ready) begin
        results_checked <= results_checked + 1;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected result event=%0d char=%02h class=%0d last=%0b",
                                    tok_out.event_res, tok_out.token_char,
                                    tok_out.token_class, tok_out.last));
        end else begin
          want = expected_tokens.pop_front();
          event_seen[int'(want.ev)]++;
          if (tok_out.event_res !== 3'(want.ev))
            report_mismatch($sformatf("event_res %0d, expected %0d",
                                      tok_out.event_res, want.ev));
          if (tok_out.token_char !== want.ch)
            report_mismatch($sformatf("token_char %02h, expected %02h",
                                      tok_out.token_char, want.ch));
          if (tok_out.token_class !== 2'(want.cls))
            report_mismatch($sformatf("token_class %0d, expected %0d",
                                      tok_out.token_class, want.cls));
          if (tok_out.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", tok_out.last, want.last));
        end
      end
      // One long hold-off lets the block fill up and stall its input.
      if (hold_left > 0) begin
        tok_out.ready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
        tok_out.ready <= 1'b0;
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
      end else if (recv_gap > 0) begin
        tok_out.ready <= 1'b0;
        recv_gap      <= recv_gap - 1;
      end else begin
        tok_out.ready <= 1'b1;
        recv_gap      <= pick_gap();
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 16'd1;
    if (rst || (char_in.valid && char_in.ready) || (tok_out.valid && tok_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Directed part: each token kind, special boundary cases, extreme bytes.
    queue_text("(a\377)");
    queue_char(CH_VT, 1'b0);
    queue_text("b");
    queue_char(CH_FF, 1'b0);
    queue_text("\"\n\200\"");
    queue_text("#x\n");
    queue_char(CH_SPACE, 1'b0);
    queue_char(CH_TAB, 1'b0);
    queue_char(CH_CR, 1'b0);
    queue_text("w\"#");
    queue_char(8'h41, 1'b1);
    queue_text("\"q");
    queue_char(CH_NUL, 1'b0);
    queue_text("z");
    queue_char(8'hFF, 1'b1);
    queue_char(CH_NUL, 1'b0);

    // Random part; the sender waits for all results at the start and now and then.
    drain_next = 1'b1;
    while (char_queue.size() < RANDOM_ITEMS) begin
      queue_fragment();
      if (stimulus_count % 60 < 3 && stimulus_count > 0) drain_next = 1'b1;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (char_queue.size() > 0 || char_in.valid || expected_tokens.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_tokens.size() > 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_tokens.size()));

    $display("Covered %0d characters (%0d ending input), %0d results, one %0d-cycle hold-off.",
             chars_accepted, eoi_accepted, results_checked, HOLD_CYCLES);
    $display("Kinds: %0d chars, %0d ends, %0d unterminated, %0d end of input, %0d empty.",
             event_seen[0], event_seen[1], event_seen[2], event_seen[3], event_seen[4]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
